@@ src/nmms_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants of the neighborhood min/max scatter unit.
package nmms_pkg;

  localparam int unsigned DOF_COUNT_DEF  = 65536;
  localparam int unsigned GROUP_SIZE_DEF = 8;
  localparam int unsigned IDX_W          = 16;
  localparam int unsigned VAL_W          = 32;
  // wide enough for the largest supported group (64 members)
  localparam int unsigned CNT_W          = 7;
  localparam int unsigned BUF_ADDR_W     = 6;

  // request opcodes on the input channel
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_MEMBER = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  // commands passed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_READ,
    CMD_MERGE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [IDX_W-1:0]         idx;
    logic signed [VAL_W-1:0]  val_a;  // load value or group minimum
    logic signed [VAL_W-1:0]  val_b;  // load value or group maximum
    logic [CNT_W-1:0]         cnt;    // buffered indices of a merge
  } cmd_t;

  // back end status toward the front end
  typedef struct packed {
    logic                  merge_done;
    logic [BUF_ADDR_W-1:0] buf_addr;
  } bk_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RD_WAIT,
    BK_MRG_RD,
    BK_MRG_WR
  } bk_state_t;

endpackage

@@ src/nmms_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and read results.
interface nmms_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic [nmms_pkg::IDX_W-1:0]          dof_index;
  logic signed [nmms_pkg::VAL_W-1:0]   value;
  logic                                last_in_group;

  modport source (output valid, op, dof_index, value, last_in_group, input ready);
  modport sink   (input valid, op, dof_index, value, last_in_group, output ready);
endinterface

interface nmms_out_if;
  logic                                valid;
  logic                                ready;
  logic [nmms_pkg::IDX_W-1:0]          read_index;
  logic signed [nmms_pkg::VAL_W-1:0]   min_value;
  logic signed [nmms_pkg::VAL_W-1:0]   max_value;

  modport source (output valid, read_index, min_value, max_value, input ready);
  modport sink   (input valid, read_index, min_value, max_value, output ready);
endinterface

@@ src/nmms_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts requests, tracks group bounds, buffers group indices.
module nmms_front #(
  parameter int unsigned GROUP_SIZE = nmms_pkg::GROUP_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  nmms_in_if.sink                    in_ch,
  output logic                       push_valid,
  output nmms_pkg::cmd_t             push_cmd,
  input  logic                       push_ready,
  input  nmms_pkg::bk_status_t       bk_status,
  output logic [nmms_pkg::IDX_W-1:0] buf_rd_data
);

  localparam int unsigned CW = $clog2(GROUP_SIZE + 1);
  localparam int unsigned BW = $clog2(GROUP_SIZE);

  logic [nmms_pkg::IDX_W-1:0]        grp_idx_r [GROUP_SIZE];
  logic [CW-1:0]                     grp_cnt_r, grp_cnt_nxt;
  logic signed [nmms_pkg::VAL_W-1:0] grp_min_r, grp_min_nxt;
  logic signed [nmms_pkg::VAL_W-1:0] grp_max_r, grp_max_nxt;
  logic                              lock_r, lock_nxt;
  logic                              accept;
  logic                              buf_we;

  // hold off all requests while the back end scatters the buffered group
  assign in_ch.ready = push_ready && !lock_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign buf_rd_data = grp_idx_r[bk_status.buf_addr[BW-1:0]];

  // classify the request and update the group tracking
  always_comb begin
    grp_cnt_nxt    = grp_cnt_r;
    grp_min_nxt    = grp_min_r;
    grp_max_nxt    = grp_max_r;
    lock_nxt       = lock_r;
    buf_we         = 1'b0;
    push_valid     = 1'b0;
    push_cmd.kind  = nmms_pkg::CMD_LOAD;
    push_cmd.idx   = in_ch.dof_index;
    push_cmd.val_a = in_ch.value;
    push_cmd.val_b = in_ch.value;
    push_cmd.cnt   = '0;
    if (bk_status.merge_done) begin
      lock_nxt = 1'b0;
    end
    if (accept) begin
      case (in_ch.op)
        nmms_pkg::OP_LOAD: begin
          push_valid = 1'b1;
        end
        nmms_pkg::OP_READ: begin
          push_valid    = 1'b1;
          push_cmd.kind = nmms_pkg::CMD_READ;
        end
        nmms_pkg::OP_MEMBER: begin
          // first member opens the group bounds
          if (grp_cnt_r == '0) begin
            grp_min_nxt = in_ch.value;
            grp_max_nxt = in_ch.value;
          end else begin
            if (in_ch.value < grp_min_r) grp_min_nxt = in_ch.value;
            if (grp_max_r < in_ch.value) grp_max_nxt = in_ch.value;
          end
          // drop indices beyond the buffer, keep folding values
          if (grp_cnt_r < CW'(GROUP_SIZE)) begin
            buf_we      = 1'b1;
            grp_cnt_nxt = grp_cnt_r + 1'b1;
          end
          if (in_ch.last_in_group) begin
            push_valid     = 1'b1;
            push_cmd.kind  = nmms_pkg::CMD_MERGE;
            push_cmd.val_a = grp_min_nxt;
            push_cmd.val_b = grp_max_nxt;
            push_cmd.cnt   = nmms_pkg::CNT_W'(grp_cnt_nxt);
            grp_cnt_nxt    = '0;
            lock_nxt       = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // group control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_cnt_r <= '0;
      grp_min_r <= '0;
      grp_max_r <= '0;
      lock_r    <= 1'b0;
    end else begin
      grp_cnt_r <= grp_cnt_nxt;
      grp_min_r <= grp_min_nxt;
      grp_max_r <= grp_max_nxt;
      lock_r    <= lock_nxt;
    end
  end

  // index buffer
  always_ff @(posedge clk) begin
    if (buf_we) begin
      grp_idx_r[grp_cnt_r[BW-1:0]] <= in_ch.dof_index;
    end
  end

endmodule

@@ src/nmms_queue.sv @@
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module nmms_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  nmms_pkg::cmd_t push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  output nmms_pkg::cmd_t pop_cmd,
  input  logic           pop_ready
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  nmms_pkg::cmd_t  q_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     fill_r;
  logic            do_push, do_pop;

  assign push_ready = (fill_r != (PW + 1)'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (!do_push && do_pop) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ src/nmms_back.sv @@
`timescale 1ns / 1ps
// Back end: bound stores, load/read handling and the merge scatter sequencer.
module nmms_back #(
  parameter int unsigned DOF_COUNT  = nmms_pkg::DOF_COUNT_DEF,
  parameter int unsigned GROUP_SIZE = nmms_pkg::GROUP_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pop_valid,
  input  nmms_pkg::cmd_t             pop_cmd,
  output logic                       pop_ready,
  output nmms_pkg::bk_status_t       bk_status,
  input  logic [nmms_pkg::IDX_W-1:0] buf_rd_data,
  nmms_out_if.source                 out_ch
);

  localparam int unsigned AW = $clog2(DOF_COUNT);
  localparam int unsigned CW = $clog2(GROUP_SIZE + 1);
  localparam int unsigned VW = nmms_pkg::VAL_W;
  localparam int unsigned IW = nmms_pkg::IDX_W;

  logic signed [VW-1:0] min_mem [DOF_COUNT];
  logic signed [VW-1:0] max_mem [DOF_COUNT];

  nmms_pkg::bk_state_t  state_r, state_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [VW-1:0] gmin_r, gmin_nxt, gmax_r, gmax_nxt;
  logic [IW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 rd_ok_r, rd_ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IW-1:0]        out_idx_r, out_idx_nxt;
  logic signed [VW-1:0] out_min_r, out_min_nxt, out_max_r, out_max_nxt;
  logic signed [VW-1:0] rd_min_r, rd_max_r;

  logic [IW-1:0]        sel_idx;
  logic [AW+IW-1:0]     sel_wide;
  logic [AW-1:0]        mem_addr;
  logic                 sel_ok;
  logic                 mem_re, mem_we;
  logic signed [VW-1:0] wr_min, wr_max;

  // address from the queue head when idle, else from the group buffer
  assign sel_idx  = (state_r == nmms_pkg::BK_IDLE) ? pop_cmd.idx : buf_rd_data;
  assign sel_ok   = (32'(sel_idx) < 32'(DOF_COUNT));
  assign sel_wide = {{AW{1'b0}}, sel_idx};
  assign mem_addr = sel_wide[AW-1:0];

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_index = out_idx_r;
  assign out_ch.min_value  = out_min_r;
  assign out_ch.max_value  = out_max_r;

  // sequencer: next state, memory strobes, output register
  always_comb begin
    state_nxt            = state_r;
    k_nxt                = k_r;
    cnt_nxt              = cnt_r;
    gmin_nxt             = gmin_r;
    gmax_nxt             = gmax_r;
    rd_idx_nxt           = rd_idx_r;
    rd_ok_nxt            = rd_ok_r;
    out_valid_nxt        = out_valid_r;
    out_idx_nxt          = out_idx_r;
    out_min_nxt          = out_min_r;
    out_max_nxt          = out_max_r;
    mem_re               = 1'b0;
    mem_we               = 1'b0;
    wr_min               = pop_cmd.val_a;
    wr_max               = pop_cmd.val_b;
    pop_ready            = 1'b0;
    bk_status.merge_done = 1'b0;
    bk_status.buf_addr   = nmms_pkg::BUF_ADDR_W'(k_r);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      nmms_pkg::BK_IDLE: begin
        if (pop_valid) begin
          case (pop_cmd.kind)
            nmms_pkg::CMD_LOAD: begin
              pop_ready = 1'b1;
              mem_we    = sel_ok;
            end
            nmms_pkg::CMD_READ: begin
              // start only when the output register frees up
              if (!out_valid_r || out_ch.ready) begin
                pop_ready  = 1'b1;
                mem_re     = sel_ok;
                rd_idx_nxt = pop_cmd.idx;
                rd_ok_nxt  = sel_ok;
                state_nxt  = nmms_pkg::BK_RD_WAIT;
              end
            end
            nmms_pkg::CMD_MERGE: begin
              pop_ready = 1'b1;
              gmin_nxt  = pop_cmd.val_a;
              gmax_nxt  = pop_cmd.val_b;
              cnt_nxt   = CW'(pop_cmd.cnt);
              k_nxt     = '0;
              state_nxt = nmms_pkg::BK_MRG_RD;
            end
            default: begin
              pop_ready = 1'b1;
            end
          endcase
        end
      end
      nmms_pkg::BK_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = rd_idx_r;
        out_min_nxt   = rd_ok_r ? rd_min_r : '0;
        out_max_nxt   = rd_ok_r ? rd_max_r : '0;
        state_nxt     = nmms_pkg::BK_IDLE;
      end
      nmms_pkg::BK_MRG_RD: begin
        if (k_r == cnt_r) begin
          bk_status.merge_done = 1'b1;
          state_nxt            = nmms_pkg::BK_IDLE;
        end else if (sel_ok) begin
          mem_re    = 1'b1;
          state_nxt = nmms_pkg::BK_MRG_WR;
        end else begin
          // skip out-of-range index
          k_nxt = k_r + 1'b1;
        end
      end
      nmms_pkg::BK_MRG_WR: begin
        mem_we    = 1'b1;
        wr_min    = (gmin_r < rd_min_r) ? gmin_r : rd_min_r;
        wr_max    = (rd_max_r < gmax_r) ? gmax_r : rd_max_r;
        k_nxt     = k_r + 1'b1;
        state_nxt = nmms_pkg::BK_MRG_RD;
      end
      default: begin
        state_nxt = nmms_pkg::BK_IDLE;
      end
    endcase
  end

  // control and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nmms_pkg::BK_IDLE;
      k_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ok_r     <= rd_ok_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    gmin_r    <= gmin_nxt;
    gmax_r    <= gmax_nxt;
    rd_idx_r  <= rd_idx_nxt;
    out_idx_r <= out_idx_nxt;
    out_min_r <= out_min_nxt;
    out_max_r <= out_max_nxt;
  end

  // bound stores with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      min_mem[mem_addr] <= wr_min;
      max_mem[mem_addr] <= wr_max;
    end
    if (mem_re) begin
      rd_min_r <= min_mem[mem_addr];
      rd_max_r <= max_mem[mem_addr];
    end
  end

endmodule

@@ src/neighborhood_min_max_scatter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the neighborhood min/max scatter unit.
//
//   channel   dir  payload                                   handshake
//   in_ch     in   op, dof_index, value, last_in_group       valid/ready
//   out_ch    out  read_index, min_value, max_value          valid/ready
//
// The front end takes one request per cycle into a four-entry command queue,
// unless the queue is full or a merge holds it off. In the back end a load writes
// the bound stores directly; a read goes through a registered store read.
// A merge does one read-modify-write of the bound stores per buffered in-range
// index, skipping the others; requests stall from the last member until it ends.
// The bound stores are not cleared by reset and hold nothing until written.
// Reads stall in the queue while an unclaimed result sits in the output register.
module neighborhood_min_max_scatter_unit #(
  parameter int unsigned DOF_COUNT  = nmms_pkg::DOF_COUNT_DEF,
  parameter int unsigned GROUP_SIZE = nmms_pkg::GROUP_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nmms_in_if.sink    in_ch,
  nmms_out_if.source out_ch
);

  logic                       push_valid, push_ready;
  nmms_pkg::cmd_t             push_cmd;
  logic                       pop_valid, pop_ready;
  nmms_pkg::cmd_t             pop_cmd;
  nmms_pkg::bk_status_t       bk_status;
  logic [nmms_pkg::IDX_W-1:0] buf_rd_data;

  nmms_front #(
    .GROUP_SIZE (GROUP_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .push_valid  (push_valid),
    .push_cmd    (push_cmd),
    .push_ready  (push_ready),
    .bk_status   (bk_status),
    .buf_rd_data (buf_rd_data)
  );

  nmms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  nmms_back #(
    .DOF_COUNT  (DOF_COUNT),
    .GROUP_SIZE (GROUP_SIZE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_cmd     (pop_cmd),
    .pop_ready   (pop_ready),
    .bk_status   (bk_status),
    .buf_rd_data (buf_rd_data),
    .out_ch      (out_ch)
  );

endmodule

@@ src/nmms_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the neighborhood min/max scatter unit, with its bind.
module nmms_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [1:0]                        in_op,
  input logic                              in_last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [nmms_pkg::IDX_W-1:0]        out_read_index,
  input logic signed [nmms_pkg::VAL_W-1:0] out_min,
  input logic signed [nmms_pkg::VAL_W-1:0] out_max
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_read_index) && $stable(out_min) && $stable(out_max))
    else $error("result payload changed while stalled");

  // reset empties the output and opens the input
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // closing a group blocks requests while the scatter runs
  a_merge_lock: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == nmms_pkg::OP_MEMBER) && in_last |=> !in_ready)
    else $error("request accepted during group merge");

endmodule

bind neighborhood_min_max_scatter_unit nmms_checker u_nmms_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_op          (in_ch.op),
  .in_last        (in_ch.last_in_group),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_index (out_ch.read_index),
  .out_min        (out_ch.min_value),
  .out_max        (out_ch.max_value)
);
